[src/dpei_pkg.sv]
// shared types and constants of the debounced pin edge interrupt block
`timescale 1ns / 1ps
`default_nettype none

package dpei_pkg;

    localparam int NUM_PINS   = 16;
    localparam int PIN_W      = 4;
    localparam int TICK_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic {
        OP_EVENT = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IE       = 3'd0,
        CFG_DE       = 3'd1,
        CFG_BOTH     = 3'd2,
        CFG_EXP_INIT = 3'd3,
        CFG_TICKS    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVENT,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic do_event;
        logic do_scan;
        logic do_flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_opcode;
        logic out_free;
        logic scan_last;
        logic held_valid;
    } t_status;

endpackage

`default_nettype wire

[src/dpei_in_if.sv]
// input request channel: pin events and time ticks
`timescale 1ns / 1ps
`default_nettype none

interface dpei_in_if import dpei_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [PIN_W-1:0]    pin_index;
    logic                pin_level;
    logic [NUM_PINS-1:0] pin_levels;

    modport source (output valid, opcode, pin_index, pin_level, pin_levels, input ready);
    modport sink   (input valid, opcode, pin_index, pin_level, pin_levels, output ready);
endinterface

`default_nettype wire

[src/dpei_out_if.sv]
// output report channel
`timescale 1ns / 1ps
`default_nettype none

interface dpei_out_if import dpei_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] report_pin;
    logic             report_level;
    logic             last;

    modport source (output valid, report_pin, report_level, last, input ready);
    modport sink   (input valid, report_pin, report_level, last, output ready);
endinterface

`default_nettype wire

[src/dpei_cfg_if.sv]
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none

interface dpei_cfg_if import dpei_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/dpei_ctrl.sv]
// controller state machine sequencing event handling, timer scan and report flush
`timescale 1ns / 1ps
`default_nettype none

module dpei_ctrl import dpei_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid) begin
                    n_state = (i_status.in_opcode == OP_TICK) ? ST_SCAN : ST_EVENT;
                end
            end
            ST_EVENT: begin
                if (i_status.out_free) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_SCAN: begin
                if (i_status.out_free && i_status.scan_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_status.held_valid || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_status.in_valid;
            end
            ST_EVENT: o_cmd.do_event = i_status.out_free;
            ST_SCAN:  o_cmd.do_scan  = i_status.out_free;
            ST_FLUSH: o_cmd.do_flush = i_status.held_valid && i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && !i_status.held_valid) |=> (r_state == ST_IDLE))
        else $error("flush with nothing held did not return to idle");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.out_free && i_status.scan_last)
        |=> (r_state == ST_FLUSH))
        else $error("scan did not end after the last pin");

    a_load_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EVENT || r_state == ST_SCAN))
        else $error("accepted request did not start work");

endmodule

`default_nettype wire

[src/dpei_dp.sv]
// datapath: masks, expected levels, debounce timers, held report and output register
`timescale 1ns / 1ps
`default_nettype none

module dpei_dp import dpei_pkg::*; #(
    parameter int PIN_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dpei_in_if.sink           i_in,
    dpei_out_if.source        o_out,
    dpei_cfg_if.sink          i_cfg,
    input  t_cmd              i_cmd,
    output t_status           o_status
);

    // pins beyond the mask width can never be enabled
    localparam int PinCnt = (PIN_COUNT < NUM_PINS) ? PIN_COUNT : NUM_PINS;
    localparam int IdxW   = (PinCnt > 1) ? $clog2(PinCnt) : 1;

    logic [NUM_PINS-1:0] r_ie;
    logic [NUM_PINS-1:0] r_de;
    logic [NUM_PINS-1:0] r_both;
    logic [NUM_PINS-1:0] r_exp;
    logic [NUM_PINS-1:0] r_active;
    logic [TICK_W-1:0]   r_ticks;
    logic [TICK_W-1:0]   r_timer [PinCnt];
    logic [NUM_PINS-1:0] n_exp;
    logic [NUM_PINS-1:0] n_active;

    logic [PIN_W-1:0]    r_pin;
    logic                r_lvl;
    logic [NUM_PINS-1:0] r_lvls;
    logic [IdxW-1:0]     r_idx;

    logic                r_held_valid;
    logic [PIN_W-1:0]    r_held_pin;
    logic                r_held_level;

    logic                r_out_valid;
    logic [PIN_W-1:0]    r_out_pin;
    logic                r_out_level;
    logic                r_out_last;

    logic                cfg_we;
    logic                out_free;
    logic                in_range;
    logic [IdxW-1:0]     ev_tidx;
    logic [TICK_W-1:0]   start_cnt;
    logic                ev_exp;
    logic                ev_start;
    logic                ev_rep;
    logic                ev_two;
    logic                ev_toggle;
    logic [PIN_W-1:0]    sp;
    logic                sc_act;
    logic [TICK_W-1:0]   sc_cnt;
    logic                sc_expire;
    logic                sc_rep;

    logic                push_en;
    logic [PIN_W-1:0]    push_pin;
    logic                push_level;
    logic                push_last;
    logic                held_set;
    logic [PIN_W-1:0]    held_pin;
    logic                held_level;

    assign cfg_we      = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_cmd.in_ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.report_pin   = r_out_pin;
    assign o_out.report_level = r_out_level;
    assign o_out.last         = r_out_last;

    assign o_status.in_valid   = i_in.valid;
    assign o_status.in_opcode  = i_in.opcode;
    assign o_status.out_free   = out_free;
    assign o_status.scan_last  = (r_idx == IdxW'(PinCnt - 1));
    assign o_status.held_valid = r_held_valid;

    // a zero delay counts as one tick
    assign start_cnt = (r_ticks == '0) ? TICK_W'(1) : r_ticks;
    assign in_range  = (int'(r_pin) < PinCnt);
    assign ev_tidx   = r_pin[IdxW-1:0];
    assign sp        = PIN_W'(r_idx);

    always_comb begin
        ev_exp    = r_exp[r_pin];
        ev_start  = in_range && r_ie[r_pin] && r_de[r_pin];
        ev_rep    = in_range && r_ie[r_pin] && !r_de[r_pin];
        ev_two    = ev_rep && r_both[r_pin] && (r_lvl != ev_exp);
        ev_toggle = ev_rep && r_both[r_pin] && (r_lvl == ev_exp);

        sc_act    = r_active[sp];
        sc_cnt    = r_timer[r_idx];
        sc_expire = sc_act && (sc_cnt <= TICK_W'(1));
        sc_rep    = sc_expire && r_ie[sp] && (r_lvls[sp] == r_exp[sp]);
    end

    // one report is held back so the final one can carry last
    always_comb begin
        push_en    = 1'b0;
        push_pin   = r_held_pin;
        push_level = r_held_level;
        push_last  = 1'b0;
        held_set   = 1'b0;
        held_pin   = r_pin;
        held_level = ev_exp;
        if (i_cmd.do_event) begin
            if (ev_two) begin
                push_en    = 1'b1;
                push_pin   = r_pin;
                push_level = ev_exp;
                held_set   = 1'b1;
                held_level = r_lvl;
            end else if (ev_rep) begin
                held_set   = 1'b1;
            end
        end
        if (i_cmd.do_scan && sc_rep) begin
            push_en    = r_held_valid;
            held_set   = 1'b1;
            held_pin   = sp;
            held_level = r_lvls[sp];
        end
        if (i_cmd.do_flush) begin
            push_en    = 1'b1;
            push_last  = 1'b1;
        end
    end

    always_comb begin
        n_exp    = r_exp;
        n_active = r_active;
        if (i_cmd.do_event && in_range) begin
            n_active[r_pin] = ev_start;
            if (ev_toggle) begin
                n_exp[r_pin] = ~r_exp[r_pin];
            end
        end
        if (i_cmd.do_scan && sc_expire) begin
            n_active[sp] = 1'b0;
            if (sc_rep && r_both[sp]) begin
                n_exp[sp] = ~r_exp[sp];
            end
        end
        if (cfg_we) begin
            case (i_cfg.index)
                CFG_IE:       n_active = r_active & i_cfg.data[NUM_PINS-1:0];
                CFG_EXP_INIT: n_exp    = i_cfg.data[NUM_PINS-1:0];
                default:      n_exp    = n_exp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ie         <= '0;
            r_de         <= '0;
            r_both       <= '0;
            r_exp        <= '0;
            r_active     <= '0;
            r_ticks      <= TICK_W'(20);
            r_idx        <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_exp    <= n_exp;
            r_active <= n_active;
            if (cfg_we) begin
                case (i_cfg.index)
                    CFG_IE:    r_ie    <= i_cfg.data[NUM_PINS-1:0];
                    CFG_DE:    r_de    <= i_cfg.data[NUM_PINS-1:0];
                    CFG_BOTH:  r_both  <= i_cfg.data[NUM_PINS-1:0];
                    CFG_TICKS: r_ticks <= i_cfg.data[TICK_W-1:0];
                    default:   r_ticks <= r_ticks;
                endcase
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.do_scan) begin
                r_idx <= r_idx + IdxW'(1);
            end
            if (i_cmd.load || i_cmd.do_flush) begin
                r_held_valid <= 1'b0;
            end else if (held_set) begin
                r_held_valid <= 1'b1;
            end
            if (push_en) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pin  <= i_in.pin_index;
            r_lvl  <= i_in.pin_level;
            r_lvls <= i_in.pin_levels;
        end
        if (held_set) begin
            r_held_pin   <= held_pin;
            r_held_level <= held_level;
        end
        if (push_en) begin
            r_out_pin   <= push_pin;
            r_out_level <= push_level;
            r_out_last  <= push_last;
        end
        if (i_cmd.do_event && ev_start) begin
            r_timer[ev_tidx] <= start_cnt;
        end else if (i_cmd.do_scan && sc_act && !sc_expire) begin
            r_timer[r_idx] <= sc_cnt - TICK_W'(1);
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en |-> out_free)
        else $error("output register overwritten while stalled");

    a_active_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~r_ie) == '0)
        else $error("timer running on a pin without interrupt enable");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_act |-> (sc_cnt != '0))
        else $error("running timer holds a zero count");

    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && !push_last) |-> held_set)
        else $error("non-final report sent without a later one held");

endmodule

`default_nettype wire

[src/debounced_pin_edge_interrupt_top.sv]
// Debounced pin edge interrupt qualifier, top level.
//
// Channels: i_in takes requests (opcode 0 = pin edge with pin_index and
// pin_level, opcode 1 = time tick with pin_levels of all pins); o_out
// gives reports (report_pin, report_level, last), last set on the final
// report of a request. i_cfg writes the five registers by index and is
// always ready. The user must write registers only while the block is
// idle; the block itself does not enforce it. An edge request is taken
// in idle; of two reports the first enters the output register in the
// event state, the final one in the flush state, after which the next
// request can be taken. A tick walks the timers, held in one register
// array, one pin per cycle while the output register is free; reports
// leave in ascending pin order, the final one from the flush state.
// Requests are handled one at a time; a new one is accepted while the last
// report still waits in the output register.
// Reset clears all masks, expected levels and running timers and loads a
// debounce delay of 20 ticks. A stalled receiver holds the output register;
// the scan pauses until it frees up, so no report is lost.
`timescale 1ns / 1ps
`default_nettype none

module debounced_pin_edge_interrupt_top import dpei_pkg::*; #(
    parameter int PIN_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpei_in_if.sink     i_in,
    dpei_out_if.source  o_out,
    dpei_cfg_if.sink    i_cfg
);

    t_cmd    cmd;
    t_status status;

    dpei_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dpei_dp #(
        .PIN_COUNT (PIN_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

`default_nettype wire

[bench/tb_debounced_pin_edge_interrupt_top.sv]
// testbench for the debounced pin edge interrupt top level
`timescale 1ns / 1ps

module tb_debounced_pin_edge_interrupt_top;
    import dpei_pkg::*;

    localparam int PINS          = 16;
    localparam int SETTLE_CYCLES = PINS + 6;

    typedef struct {
        t_opcode             op;
        logic [PIN_W-1:0]    pin;
        logic                level;
        logic [NUM_PINS-1:0] levels;
    } t_request;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic             level;
        logic             last;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dpei_in_if  in_ch ();
    dpei_out_if out_ch ();
    dpei_cfg_if cfg_ch ();

    debounced_pin_edge_interrupt_top #(.PIN_COUNT(PINS)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    // shadow registers and pin state
    logic [NUM_PINS-1:0] irq_en;
    logic [NUM_PINS-1:0] db_en;
    logic [NUM_PINS-1:0] both_edge;
    logic [NUM_PINS-1:0] exp_levels;
    logic [NUM_PINS-1:0] timer_on;
    logic [TICK_W-1:0]   delay_ticks;
    logic [TICK_W-1:0]   timer_left [NUM_PINS];

    t_request request_backlog[$];
    t_report  expected_reports[$];
    int       mismatch_count = 0;
    bit       calm = 1'b0;

    function automatic void reset_shadow();
        irq_en      = '0;
        db_en       = '0;
        both_edge   = '0;
        exp_levels  = '0;
        timer_on    = '0;
        delay_ticks = TICK_W'(20);
        for (int p = 0; p < NUM_PINS; p++) timer_left[p] = '0;
    endfunction

    function automatic void apply_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IE: begin
                irq_en   = data[NUM_PINS-1:0];
                // disabling a pin drops its running timer
                timer_on = timer_on & data[NUM_PINS-1:0];
            end
            CFG_DE:       db_en       = data[NUM_PINS-1:0];
            CFG_BOTH:     both_edge   = data[NUM_PINS-1:0];
            CFG_EXP_INIT: exp_levels  = data[NUM_PINS-1:0];
            CFG_TICKS:    delay_ticks = data[TICK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_reports(t_request r);
        int      n;
        t_report rep;
        n = 0;
        if (r.op == OP_EVENT) begin
            timer_on[r.pin] = 1'b0;
            if (irq_en[r.pin]) begin
                if (db_en[r.pin]) begin
                    timer_left[r.pin] = (delay_ticks == '0) ? TICK_W'(1) : delay_ticks;
                    timer_on[r.pin]   = 1'b1;
                end else begin
                    expected_reports.push_back('{r.pin, exp_levels[r.pin], 1'b0});
                    n++;
                    if (both_edge[r.pin]) begin
                        if (r.level != exp_levels[r.pin]) begin
                            expected_reports.push_back('{r.pin, r.level, 1'b0});
                            n++;
                        end else begin
                            exp_levels[r.pin] = ~exp_levels[r.pin];
                        end
                    end
                end
            end
        end else begin
            for (int p = 0; p < NUM_PINS; p++) begin
                if (timer_on[p]) begin
                    if (timer_left[p] > TICK_W'(1)) begin
                        timer_left[p] = timer_left[p] - 1'b1;
                    end else begin
                        timer_left[p] = '0;
                        timer_on[p]   = 1'b0;
                        if (irq_en[p] && r.levels[p] == exp_levels[p]) begin
                            expected_reports.push_back('{PIN_W'(p), r.levels[p], 1'b0});
                            n++;
                            if (both_edge[p]) exp_levels[p] = ~exp_levels[p];
                        end
                    end
                end
            end
        end
        if (n > 0) begin
            rep      = expected_reports.pop_back();
            rep.last = 1'b1;
            expected_reports.push_back(rep);
        end
    endfunction

    function automatic void add_edge(int pin, bit level);
        t_request r;
        r.op     = OP_EVENT;
        r.pin    = PIN_W'(pin);
        r.level  = level;
        r.levels = NUM_PINS'($urandom);
        request_backlog.push_back(r);
    endfunction

    function automatic void add_tick(logic [NUM_PINS-1:0] levels);
        t_request r;
        r.op     = OP_TICK;
        r.pin    = PIN_W'($urandom);
        r.level  = 1'($urandom);
        r.levels = levels;
        request_backlog.push_back(r);
    endfunction

    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        apply_register(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    // idle means nothing queued, nothing in flight, plus time for a tick scan
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || in_ch.valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_setup(int ph);
        logic [CFG_DATA_W-1:0] ticks;
        if (ph == 1)      ticks = '1;
        else if (ph == 3) ticks = '0;
        else              ticks = CFG_DATA_W'($urandom_range(1, 4));
        write_register(CFG_IE, (ph % 3 == 0) ? '1 : CFG_DATA_W'($urandom | $urandom));
        write_register(CFG_DE, CFG_DATA_W'($urandom));
        write_register(CFG_BOTH, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1)) write_register(CFG_EXP_INIT, CFG_DATA_W'($urandom));
        write_register(CFG_TICKS, ticks);
    endtask

    task automatic queue_random_requests(int count);
        logic [NUM_PINS-1:0] guess;
        guess = exp_levels;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: add_edge($urandom_range(0, NUM_PINS - 1), 1'($urandom));
                9:             add_tick(NUM_PINS'($urandom));
                // mostly near the expected levels so expiring timers report
                default:       add_tick(guess ^ NUM_PINS'($urandom & $urandom & $urandom));
            endcase
        end
    endtask

    // request driver
    int       in_gap = 0;
    t_request in_cur;

    always @(posedge i_clk) begin : request_driver
        logic next_valid;
        next_valid = in_ch.valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            in_gap     = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_reports(in_cur);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (request_backlog.size() != 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        in_gap = $urandom_range(1, 18) - 1;
                    end else begin
                        in_cur = request_backlog.pop_front();
                        in_ch.opcode     <= in_cur.op;
                        in_ch.pin_index  <= in_cur.pin;
                        in_ch.pin_level  <= in_cur.level;
                        in_ch.pin_levels <= in_cur.levels;
                        next_valid = 1'b1;
                    end
                end
            end
        end
        in_ch.valid <= next_valid;
    end

    // report monitor and receiver stalls
    int out_gap = 0;

    always @(posedge i_clk) begin : report_monitor
        t_report want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected report: pin %0d level %0b last %0b",
                                 out_ch.report_pin, out_ch.report_level, out_ch.last);
                end else begin
                    want = expected_reports.pop_front();
                    if (out_ch.report_pin !== want.pin || out_ch.report_level !== want.level
                            || out_ch.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"report mismatch: expected pin %0d level %0b last %0b,",
                                      " got pin %0d level %0b last %0b"},
                                     want.pin, want.level, want.last, out_ch.report_pin,
                                     out_ch.report_level, out_ch.last);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 18) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_EVENT;
        in_ch.pin_index  = '0;
        in_ch.pin_level  = 1'b0;
        in_ch.pin_levels = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_IE;
        cfg_ch.data      = '0;
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: debounced, immediate and both-edge pins
        write_register(CFG_TICKS, CFG_DATA_W'(2));
        write_register(CFG_IE, CFG_DATA_W'(16'hFFFF));
        write_register(CFG_DE, CFG_DATA_W'(16'h00FF));
        write_register(CFG_BOTH, CFG_DATA_W'(16'h0F0F));
        write_register(CFG_EXP_INIT, CFG_DATA_W'(16'h03E0));
        add_edge(0, 1'b0);
        add_edge(5, 1'b1);
        add_edge(8, 1'b0);    // level differs from expected: two reports
        add_edge(9, 1'b1);    // level matches: expected toggles
        add_edge(15, 1'b1);
        add_tick(16'h0000);
        add_tick(16'hFFFF);
        add_edge(1, 1'b1);
        add_edge(1, 1'b0);    // restarts the running timer
        add_tick(16'h03E0);
        add_tick(16'h03E0);
        wait_drained();

        // disabled pins, zero delay
        write_register(CFG_IE, CFG_DATA_W'(16'hFC00));
        write_register(CFG_DE, CFG_DATA_W'(0));
        write_register(CFG_TICKS, CFG_DATA_W'(0));
        add_edge(3, 1'b1);
        add_edge(10, 1'b1);
        add_edge(11, 1'b0);
        wait_drained();

        // every pin debounced, then one tick expires them all
        write_register(CFG_IE, '1);
        write_register(CFG_DE, '1);
        for (int p = 0; p < NUM_PINS; p++) add_edge(p, 1'($urandom));
        wait_drained();
        add_tick(exp_levels);
        add_tick(~exp_levels);
        wait_drained();

        // all interrupts off
        write_register(CFG_BOTH, '1);
        write_register(CFG_EXP_INIT, '1);
        write_register(CFG_IE, '0);
        add_edge(4, 1'b1);
        add_tick(16'hFFFF);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            random_setup(ph);
            if (ph == 5) calm = 1'b1;
            queue_random_requests(15);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[debounced_pin_edge_interrupt_top.f]
src/dpei_pkg.sv
src/dpei_in_if.sv
src/dpei_out_if.sv
src/dpei_cfg_if.sv
src/dpei_ctrl.sv
src/dpei_dp.sv
src/debounced_pin_edge_interrupt_top.sv
bench/tb_debounced_pin_edge_interrupt_top.sv
